>>> rtl/core/sirb_pkg.sv
// Shared types, constants and codes for the snapshot interpolation ring buffer.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps
`default_nettype none

package sirb_pkg;

  localparam int unsigned RingDepthDef = 16;
  localparam logic [15:0] DelayReset   = 16'd150;
  localparam int unsigned MinFill      = 2;

  localparam int unsigned NumW  = 48;
  localparam int unsigned DenW  = 32;
  localparam int unsigned FracW = 17;

  // Outcome codes
  localparam logic [2:0] OUT_PUSHED = 3'd0;
  localparam logic [2:0] OUT_INTERP = 3'd1;
  localparam logic [2:0] OUT_NEWEST = 3'd2;
  localparam logic [2:0] OUT_EQUAL  = 3'd3;
  localparam logic [2:0] OUT_FEW    = 3'd4;

  // Item kinds
  localparam logic KIND_PUSH  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Register indexes
  localparam logic REG_DELAY = 1'b0;
  localparam logic REG_OWNED = 1'b1;

  typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [15:0] yaw;
    logic [15:0] pitch;
    logic [15:0] health;
    logic [15:0] anim_code;
    logic [7:0]  behav_code;
    logic [7:0]  flags;
    logic [31:0] target_id;
  } sirb_payload_t;

endpackage

`default_nettype wire

>>> rtl/core/sirb_ring.sv
// Snapshot ring storage: a stamp memory and a payload memory, one write port,
// one registered read port each. Depends on sirb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sirb_ring #(
  parameter int unsigned RingDepth = 16,
  parameter int unsigned IdxW      = $clog2(RingDepth)
) (
  input  wire logic                   clk_i,
  input  wire logic                   we_i,
  input  wire logic [IdxW-1:0]        waddr_i,
  input  wire logic [31:0]            wstamp_i,
  input  wire sirb_pkg::sirb_payload_t wpay_i,
  input  wire logic [IdxW-1:0]        stamp_raddr_i,
  input  wire logic [IdxW-1:0]        pay_raddr_i,
  output      logic [31:0]            stamp_rdata_o,
  output      sirb_pkg::sirb_payload_t pay_rdata_o
);
  import sirb_pkg::*;

  logic [31:0]   stamp_mem [RingDepth];
  sirb_payload_t pay_mem   [RingDepth];

  // Write on push, read one entry per memory each cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      stamp_mem[waddr_i] <= wstamp_i;
      pay_mem[waddr_i]   <= wpay_i;
    end
    stamp_rdata_o <= stamp_mem[stamp_raddr_i];
    pay_rdata_o   <= pay_mem[pay_raddr_i];
  end

endmodule

`default_nettype wire

>>> rtl/core/sirb_div.sv
// Restoring unsigned divider, one quotient bit per cycle (48 / 32 bits).
// Depends on sirb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sirb_div (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  input  wire logic [sirb_pkg::NumW-1:0] num_i,
  input  wire logic [sirb_pkg::DenW-1:0] den_i,
  output      logic                    busy_o,
  output      logic [sirb_pkg::NumW-1:0] quot_o
);
  import sirb_pkg::*;

  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [CntW-1:0] cnt_q;
  logic            busy_q;
  logic [DenW-1:0] rem_q, den_q;
  logic [NumW-1:0] quo_q;
  logic [DenW:0]   rem_sh;
  logic            fits;

  assign rem_sh = {rem_q, quo_q[NumW-1]};
  assign fits   = rem_sh >= {1'b0, den_q};

  // Control: count the quotient bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CntW'(NumW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Datapath: shift in one dividend bit, subtract when it fits
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= fits ? DenW'(rem_sh - {1'b0, den_q}) : rem_sh[DenW-1:0];
      quo_q <= {quo_q[NumW-2:0], fits};
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quo_q;

endmodule

`default_nettype wire

>>> rtl/core/snapshot_interp_ring_buffer.sv
// Push: the ring is written (unless owned) in the dispatch state and the result
// is registered in the finish state. Query: a walk over stored entries (newest
// first, a read and a compare state with one stamp memory read each), then the
// 48-step divider and a shared multiplier over five lerps.
// One item is processed at a time; the result register frees the input side.
// Reset clears fill count, head, current state and registers; ring memory is
// not cleared.
`timescale 1ns / 1ps
`default_nettype none

module snapshot_interp_ring_buffer #(
  parameter int unsigned RING_DEPTH = sirb_pkg::RingDepthDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready,
  input  wire logic        in_valid_i,
  output      logic        in_ready_o,
  input  wire logic        kind_i,
  input  wire logic [31:0] stamp_i,
  input  wire logic signed [31:0] pos_x_i,
  input  wire logic signed [31:0] pos_y_i,
  input  wire logic signed [31:0] pos_z_i,
  input  wire logic signed [15:0] yaw_i,
  input  wire logic signed [15:0] pitch_i,
  input  wire logic [15:0] health_i,
  input  wire logic [15:0] anim_code_i,
  input  wire logic [7:0]  behav_code_i,
  input  wire logic [7:0]  flags_i,
  input  wire logic [31:0] target_id_i,
  output      logic        out_valid_o,
  input  wire logic        out_ready_i,
  output      logic [2:0]  outcome_o,
  output      logic signed [31:0] out_pos_x_o,
  output      logic signed [31:0] out_pos_y_o,
  output      logic signed [31:0] out_pos_z_o,
  output      logic signed [15:0] out_yaw_o,
  output      logic signed [15:0] out_pitch_o,
  output      logic [15:0] out_health_o,
  output      logic [15:0] out_anim_code_o,
  output      logic [7:0]  out_behav_code_o,
  output      logic [7:0]  out_flags_o,
  output      logic [31:0] out_target_id_o
);
  import sirb_pkg::*;

  localparam int unsigned IdxW = $clog2(RING_DEPTH);
  localparam int unsigned CntW = $clog2(RING_DEPTH + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(RING_DEPTH - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_WALK_RD, S_WALK_CMP, S_LD_RD, S_LD_CAP, S_DIV_START,
    S_FETCH_OLD, S_FETCH_NEW, S_DIV_WAIT, S_LERP_MUL, S_LERP_ADD, S_FINISH
  } state_e;

  state_e        state_q;
  logic [15:0]   delay_q;
  logic          owned_q;
  logic [IdxW-1:0] head_q, idx_q, prev_idx_q, older_q, newer_q, ld_idx_q;
  logic [CntW-1:0] fill_q, walk_q;
  logic          kind_q;
  logic [31:0]   stamp_q, target_q, prev_stamp_q, old_stamp_q, new_stamp_q;
  sirb_payload_t in_pay_q, cur_q, pay_a_q, pay_b_q, out_pay_q;
  logic [2:0]    outcome_q, out_outcome_q;
  logic          out_valid_q;
  logic [FracW-1:0] frac_q;
  logic [2:0]    lane_q;
  logic signed [50:0] prod_q;

  // Configuration port
  logic cfg_we;
  assign cfg_we = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    unique case (paddr[2])
      REG_DELAY: prdata = {16'b0, delay_q};
      REG_OWNED: prdata = {31'b0, owned_q};
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= DelayReset;
      owned_q <= 1'b0;
    end else if (cfg_we) begin
      unique case (paddr[2])
        REG_DELAY: delay_q <= pwdata[15:0];
        REG_OWNED: owned_q <= pwdata[0];
        default:   ;
      endcase
    end
  end

  // Ring memories
  logic            ring_we;
  logic [IdxW-1:0] pay_raddr;
  logic [31:0]     stamp_rdata;
  sirb_payload_t   pay_rdata;

  assign ring_we = (state_q == S_DISPATCH) && (kind_q == KIND_PUSH) && !owned_q;

  always_comb begin
    unique case (state_q)
      S_LD_RD:     pay_raddr = ld_idx_q;
      S_FETCH_OLD: pay_raddr = newer_q;
      default:     pay_raddr = older_q;
    endcase
  end

  sirb_ring #(.RingDepth(RING_DEPTH), .IdxW(IdxW)) u_ring (
    .clk_i         (clk_i),
    .we_i          (ring_we),
    .waddr_i       (head_q),
    .wstamp_i      (stamp_q),
    .wpay_i        (in_pay_q),
    .stamp_raddr_i (idx_q),
    .pay_raddr_i   (pay_raddr),
    .stamp_rdata_o (stamp_rdata),
    .pay_rdata_o   (pay_rdata)
  );

  // Fraction divider
  logic            div_start, div_busy;
  logic [NumW-1:0] div_quot;
  logic [31:0]     gap;
  assign gap       = new_stamp_q - old_stamp_q;
  assign div_start = (state_q == S_DIV_START);

  sirb_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   ({target_q - old_stamp_q, 16'b0}),
    .den_i   (gap),
    .busy_o  (div_busy),
    .quot_o  (div_quot)
  );

  // Lerp lane select and shared multiplier
  logic signed [32:0] lerp_a, lerp_b, lerp_diff;
  logic signed [34:0] lerp_sum;
  always_comb begin
    unique case (lane_q)
      3'd0: begin
        lerp_a = {pay_a_q.pos_x[31], pay_a_q.pos_x};
        lerp_b = {pay_b_q.pos_x[31], pay_b_q.pos_x};
      end
      3'd1: begin
        lerp_a = {pay_a_q.pos_y[31], pay_a_q.pos_y};
        lerp_b = {pay_b_q.pos_y[31], pay_b_q.pos_y};
      end
      3'd2: begin
        lerp_a = {pay_a_q.pos_z[31], pay_a_q.pos_z};
        lerp_b = {pay_b_q.pos_z[31], pay_b_q.pos_z};
      end
      3'd3: begin
        lerp_a = {{17{pay_a_q.yaw[15]}}, pay_a_q.yaw};
        lerp_b = {{17{pay_b_q.yaw[15]}}, pay_b_q.yaw};
      end
      default: begin
        lerp_a = {{17{pay_a_q.pitch[15]}}, pay_a_q.pitch};
        lerp_b = {{17{pay_b_q.pitch[15]}}, pay_b_q.pitch};
      end
    endcase
    lerp_diff = lerp_b - lerp_a;
    lerp_sum  = {{2{lerp_a[32]}}, lerp_a} + prod_q[50:16];
  end

  logic [IdxW-1:0] newest_idx, idx_dec;
  assign newest_idx = (head_q == '0) ? LastIdx : head_q - 1'b1;
  assign idx_dec    = (idx_q == '0) ? LastIdx : idx_q - 1'b1;

  // Control state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      fill_q      <= '0;
      cur_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // Hold the result until its transfer, refill from the finish step
      if (state_q == S_FINISH && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          if (kind_q == KIND_PUSH) begin
            if (!owned_q) begin
              head_q <= (head_q == LastIdx) ? '0 : head_q + 1'b1;
              if (fill_q != CntW'(RING_DEPTH)) begin
                fill_q <= fill_q + 1'b1;
              end
            end
            cur_q     <= in_pay_q;
            outcome_q <= OUT_PUSHED;
            state_q   <= S_FINISH;
          end else if (fill_q < CntW'(MinFill)) begin
            outcome_q <= OUT_FEW;
            state_q   <= S_FINISH;
          end else begin
            idx_q   <= newest_idx;
            walk_q  <= '0;
            state_q <= S_WALK_RD;
          end
        end
        S_WALK_RD: state_q <= S_WALK_CMP;
        S_WALK_CMP: begin
          if (stamp_rdata <= target_q) begin
            if (walk_q == '0) begin
              ld_idx_q  <= newest_idx;
              outcome_q <= OUT_NEWEST;
              state_q   <= S_LD_RD;
            end else begin
              older_q     <= idx_q;
              newer_q     <= prev_idx_q;
              old_stamp_q <= stamp_rdata;
              new_stamp_q <= prev_stamp_q;
              state_q     <= S_DIV_START;
            end
          end else if (walk_q + 1'b1 == fill_q) begin
            ld_idx_q  <= newest_idx;
            outcome_q <= OUT_NEWEST;
            state_q   <= S_LD_RD;
          end else begin
            prev_stamp_q <= stamp_rdata;
            prev_idx_q   <= idx_q;
            idx_q        <= idx_dec;
            walk_q       <= walk_q + 1'b1;
            state_q      <= S_WALK_RD;
          end
        end
        S_LD_RD: state_q <= S_LD_CAP;
        S_LD_CAP: begin
          cur_q   <= pay_rdata;
          state_q <= S_FINISH;
        end
        S_DIV_START: begin
          if (gap == '0) begin
            ld_idx_q  <= newer_q;
            outcome_q <= OUT_EQUAL;
            state_q   <= S_LD_RD;
          end else begin
            state_q <= S_FETCH_OLD;
          end
        end
        S_FETCH_OLD: begin
          pay_a_q <= pay_rdata;
          state_q <= S_FETCH_NEW;
        end
        S_FETCH_NEW: begin
          pay_b_q <= pay_rdata;
          state_q <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (!div_busy) begin
            frac_q  <= (div_quot > NumW'(65536)) ? FracW'(65536) : div_quot[FracW-1:0];
            lane_q  <= 3'd0;
            state_q <= S_LERP_MUL;
          end
        end
        S_LERP_MUL: begin
          prod_q  <= lerp_diff * $signed({1'b0, frac_q});
          state_q <= S_LERP_ADD;
        end
        S_LERP_ADD: begin
          unique case (lane_q)
            3'd0:    cur_q.pos_x <= lerp_sum[31:0];
            3'd1:    cur_q.pos_y <= lerp_sum[31:0];
            3'd2:    cur_q.pos_z <= lerp_sum[31:0];
            3'd3:    cur_q.yaw   <= lerp_sum[15:0];
            default: cur_q.pitch <= lerp_sum[15:0];
          endcase
          if (lane_q == 3'd4) begin
            cur_q.health     <= pay_b_q.health;
            cur_q.anim_code  <= pay_b_q.anim_code;
            cur_q.behav_code <= pay_b_q.behav_code;
            cur_q.flags      <= pay_b_q.flags;
            cur_q.target_id  <= pay_b_q.target_id;
            outcome_q        <= OUT_INTERP;
            state_q          <= S_FINISH;
          end else begin
            lane_q  <= lane_q + 1'b1;
            state_q <= S_LERP_MUL;
          end
        end
        S_FINISH: begin
          if (!out_valid_q || out_ready_i) begin
            out_outcome_q <= outcome_q;
            out_pay_q     <= cur_q;
            state_q       <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Capture the input transfer
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      kind_q   <= kind_i;
      stamp_q  <= stamp_i;
      target_q <= stamp_i - {16'b0, delay_q};
      in_pay_q <= '{pos_x: pos_x_i, pos_y: pos_y_i, pos_z: pos_z_i, yaw: yaw_i,
                    pitch: pitch_i, health: health_i, anim_code: anim_code_i,
                    behav_code: behav_code_i, flags: flags_i, target_id: target_id_i};
    end
  end

  assign in_ready_o       = (state_q == S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign outcome_o        = out_outcome_q;
  assign out_pos_x_o      = out_pay_q.pos_x;
  assign out_pos_y_o      = out_pay_q.pos_y;
  assign out_pos_z_o      = out_pay_q.pos_z;
  assign out_yaw_o        = out_pay_q.yaw;
  assign out_pitch_o      = out_pay_q.pitch;
  assign out_health_o     = out_pay_q.health;
  assign out_anim_code_o  = out_pay_q.anim_code;
  assign out_behav_code_o = out_pay_q.behav_code;
  assign out_flags_o      = out_pay_q.flags;
  assign out_target_id_o  = out_pay_q.target_id;

endmodule

`default_nettype wire

>>> tb/tb.sv
// Self-checking bench for snapshot_interp_ring_buffer: a queue-fed driver, a
// receiver with random and long stalls, and an in-bench predictor of the ring.
// Depends on sirb_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb;
  import sirb_pkg::*;

  localparam int unsigned Depth     = 16;
  localparam int unsigned StallLen  = 400;
  localparam int unsigned DogLimit  = 20000;
  localparam int unsigned DrainWait = 150;

  typedef struct packed {
    logic          kind;
    logic [31:0]   stamp;
    sirb_payload_t pl;
  } snap_item_t;

  typedef struct packed {
    logic [2:0]    outcome;
    sirb_payload_t st;
  } state_view_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  logic        in_valid = 1'b0;
  logic        in_ready_o;
  snap_item_t  drv_item = '0;
  logic        out_valid_o;
  logic        out_ready = 1'b0;
  wire state_view_t got;

  snapshot_interp_ring_buffer dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i(in_valid), .in_ready_o,
    .kind_i(drv_item.kind), .stamp_i(drv_item.stamp),
    .pos_x_i(drv_item.pl.pos_x), .pos_y_i(drv_item.pl.pos_y),
    .pos_z_i(drv_item.pl.pos_z), .yaw_i(drv_item.pl.yaw),
    .pitch_i(drv_item.pl.pitch), .health_i(drv_item.pl.health),
    .anim_code_i(drv_item.pl.anim_code), .behav_code_i(drv_item.pl.behav_code),
    .flags_i(drv_item.pl.flags), .target_id_i(drv_item.pl.target_id),
    .out_valid_o, .out_ready_i(out_ready),
    .outcome_o(got.outcome), .out_pos_x_o(got.st.pos_x), .out_pos_y_o(got.st.pos_y),
    .out_pos_z_o(got.st.pos_z), .out_yaw_o(got.st.yaw), .out_pitch_o(got.st.pitch),
    .out_health_o(got.st.health), .out_anim_code_o(got.st.anim_code),
    .out_behav_code_o(got.st.behav_code), .out_flags_o(got.st.flags),
    .out_target_id_o(got.st.target_id)
  );

  // Predictor state
  logic [31:0]   ring_stamp [Depth];
  sirb_payload_t ring_snap  [Depth];
  logic [3:0]    head = '0;
  int unsigned   fill = 0;
  sirb_payload_t cur_state = '0;
  logic [15:0]   delay_q = DelayReset;
  logic          owned_q = 1'b0;

  snap_item_t  pending_items [$];
  state_view_t expected_states [$];
  int unsigned send_idle = 0, recv_idle = 0;
  logic        hold_req = 1'b0, hold_started = 1'b0;
  int unsigned hold_cnt = 0, dog_cnt = 0, errors = 0;
  logic [31:0] t_now = 32'd1000;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint lerp(longint a, longint b, longint frac);
    return a + (((b - a) * frac) >>> 16);
  endfunction

  // Apply one transfer to the predictor and queue the expected state
  task automatic predict(input snap_item_t it);
    state_view_t r;
    logic [31:0] tgt;
    logic [3:0]  idx, older, newer;
    logic [31:0] gap;
    longint      frac;
    logic        found;
    found = 1'b0;
    older = '0;
    newer = '0;
    if (it.kind == KIND_PUSH) begin
      if (!owned_q) begin
        ring_stamp[head] = it.stamp;
        ring_snap[head]  = it.pl;
        head = head + 4'd1;
        if (fill < Depth) fill++;
      end
      cur_state = it.pl;
      r.outcome = OUT_PUSHED;
    end else if (fill < MinFill) begin
      r.outcome = OUT_FEW;
    end else begin
      tgt = it.stamp - {16'd0, delay_q};
      for (int i = 0; i < fill; i++) begin
        idx = head - 4'd1 - 4'(i);
        if (ring_stamp[idx] <= tgt) begin
          if (i > 0) begin
            older = idx;
            newer = idx + 4'd1;
            found = 1'b1;
          end
          break;
        end
      end
      if (!found) begin
        cur_state = ring_snap[head - 4'd1];
        r.outcome = OUT_NEWEST;
      end else begin
        gap = ring_stamp[newer] - ring_stamp[older];
        if (gap == 0) begin
          cur_state = ring_snap[newer];
          r.outcome = OUT_EQUAL;
        end else begin
          frac = longint'({32'd0, tgt - ring_stamp[older]} << 16) / longint'(gap);
          if (frac > 65536) frac = 65536;
          cur_state = ring_snap[newer];
          cur_state.pos_x = 32'(lerp(longint'($signed(ring_snap[older].pos_x)),
                                     longint'($signed(ring_snap[newer].pos_x)), frac));
          cur_state.pos_y = 32'(lerp(longint'($signed(ring_snap[older].pos_y)),
                                     longint'($signed(ring_snap[newer].pos_y)), frac));
          cur_state.pos_z = 32'(lerp(longint'($signed(ring_snap[older].pos_z)),
                                     longint'($signed(ring_snap[newer].pos_z)), frac));
          cur_state.yaw   = 16'(lerp(longint'($signed(ring_snap[older].yaw)),
                                     longint'($signed(ring_snap[newer].yaw)), frac));
          cur_state.pitch = 16'(lerp(longint'($signed(ring_snap[older].pitch)),
                                     longint'($signed(ring_snap[newer].pitch)), frac));
          r.outcome = OUT_INTERP;
        end
      end
    end
    r.st = cur_state;
    expected_states.insert(expected_states.size(), r);
  endtask

  task automatic check_field(input string name, input logic [31:0] e, input logic [31:0] a);
    if (e !== a) begin
      errors++;
      $display("%0t mismatch %s: expected %h actual %h", $realtime, name, e, a);
    end
  endtask

  // Sender: hold the item until transfer, then maybe offer the next one
  always @(posedge clk_i) begin
    if (rst_ni && (!in_valid || in_ready_o)) begin
      if (pending_items.size() > 0 && $urandom_range(99) >= send_idle) begin
        drv_item <= pending_items.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus one long hold-off
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_req && !hold_started) begin
        hold_started <= 1'b1;
        hold_cnt     <= StallLen;
        out_ready    <= 1'b0;
      end else if (hold_cnt > 0) begin
        hold_cnt  <= hold_cnt - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  // Monitor: predict on input transfer, compare on output transfer
  always @(posedge clk_i) begin
    state_view_t e;
    if (rst_ni) begin
      if (in_valid && in_ready_o) predict(drv_item);
      if (out_valid_o && out_ready) begin
        if (expected_states.size() == 0) begin
          errors++;
          $display("%0t unexpected result: outcome %0d", $realtime, got.outcome);
        end else begin
          e = expected_states.pop_front();
          check_field("outcome", 32'(e.outcome), 32'(got.outcome));
          check_field("pos_x", e.st.pos_x, got.st.pos_x);
          check_field("pos_y", e.st.pos_y, got.st.pos_y);
          check_field("pos_z", e.st.pos_z, got.st.pos_z);
          check_field("yaw", 32'(e.st.yaw), 32'(got.st.yaw));
          check_field("pitch", 32'(e.st.pitch), 32'(got.st.pitch));
          check_field("health", 32'(e.st.health), 32'(got.st.health));
          check_field("anim_code", 32'(e.st.anim_code), 32'(got.st.anim_code));
          check_field("behav_code", 32'(e.st.behav_code), 32'(got.st.behav_code));
          check_field("flags", 32'(e.st.flags), 32'(got.st.flags));
          check_field("target_id", e.st.target_id, got.st.target_id);
        end
      end
    end
  end

  // Watchdog: count cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
      dog_cnt <= 0;
    end else begin
      dog_cnt <= dog_cnt + 1;
      if (dog_cnt >= DogLimit) begin
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  task automatic apb_write(input logic reg_idx, input logic [31:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_idx == REG_DELAY) delay_q = data[15:0];
    else owned_q = data[0];
  endtask

  function automatic sirb_payload_t rand_payload();
    sirb_payload_t p;
    p = $bits(sirb_payload_t)'({$urandom, $urandom, $urandom, $urandom, $urandom,
                                $urandom, $urandom});
    // Keep positions small most of the time so lerps are readable
    if ($urandom_range(3) != 0) begin
      p.pos_x = 32'($signed(p.pos_x) >>> 12);
      p.pos_y = 32'($signed(p.pos_y) >>> 12);
      p.pos_z = 32'($signed(p.pos_z) >>> 12);
    end
    return p;
  endfunction

  task automatic add_push(input logic [31:0] stamp, input sirb_payload_t p);
    snap_item_t it;
    it.kind  = KIND_PUSH;
    it.stamp = stamp;
    it.pl    = p;
    pending_items.insert(pending_items.size(), it);
  endtask

  task automatic add_query(input logic [31:0] render);
    snap_item_t it;
    it.kind  = KIND_QUERY;
    it.stamp = render;
    it.pl    = rand_payload();
    pending_items.insert(pending_items.size(), it);
  endtask

  task automatic add_random(input int unsigned n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0: add_push($urandom, rand_payload());
        1: add_query($urandom);
        2, 3, 4, 5: begin
          t_now = t_now + $urandom_range(($urandom_range(7) == 0) ? 0 : 200);
          add_push(t_now, rand_payload());
        end
        default: add_query(t_now + delay_q - $urandom_range(600) + $urandom_range(50));
      endcase
    end
  endtask

  task automatic drain();
    wait (pending_items.size() == 0 && !in_valid && expected_states.size() == 0);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  initial begin
    sirb_payload_t pmax, pmin;
    pmax = '1;
    pmax.pos_x = 32'h7fffffff;
    pmax.pos_y = 32'h7fffffff;
    pmax.pos_z = 32'h7fffffff;
    pmax.yaw   = 16'h7fff;
    pmax.pitch = 16'h7fff;
    pmin = '0;
    pmin.pos_x = 32'h80000000;
    pmin.pos_y = 32'h80000000;
    pmin.pos_z = 32'h80000000;
    pmin.yaw   = 16'h8000;
    pmin.pitch = 16'h8000;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: too few entries, extremes, bracket and fallback cases
    add_query(32'd5000);
    add_push(32'd1000, pmax);
    add_query(32'd1200);
    add_push(32'd1100, pmin);
    add_query(32'd1200);
    add_query(32'd1150);
    add_query(32'd0);
    add_query(32'd600);
    add_query(32'hffffffff);
    add_push(32'd1100, pmax);
    add_query(32'd1250);
    for (int i = 0; i < 12; i++) add_push(32'd1200 + 32'(i * 37), rand_payload());
    add_query(32'd1300);
    add_query(32'd1500);
    t_now = 32'd1700;
    drain();

    // Phase: no idling, zero delay, long receiver hold-off
    apb_write(REG_DELAY, 32'd0);
    apb_write(REG_OWNED, 32'd0);
    hold_req = 1'b1;
    add_random(260);
    drain();

    // Phase: sender mostly idle, maximum delay, locally owned at first
    send_idle = 83;
    apb_write(REG_DELAY, 32'd65535);
    apb_write(REG_OWNED, 32'd1);
    add_random(40);
    drain();
    apb_write(REG_OWNED, 32'd0);
    add_random(220);
    drain();

    // Phase: receiver mostly stalling, random delay
    send_idle = 0;
    recv_idle = 83;
    apb_write(REG_DELAY, 32'($urandom_range(400)));
    t_now = 32'hffffff00;
    add_random(260);
    drain();

    // Phase: both idle at a lower rate, reset delay value
    send_idle = 28;
    recv_idle = 28;
    apb_write(REG_DELAY, 32'(DelayReset));
    add_random(260);
    drain();

    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
